// ----- rtl/core/stable_event_priority_queue_assert.svh -----
// Assertion macros shared by the event queue RTL.
// Each macro expands to one labelled concurrent assertion on a rising clock edge.
`ifndef STABLE_EVENT_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_EVENT_PRIORITY_QUEUE_ASSERT_SVH

// The condition holds at every edge outside reset.
`define SEPQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SEPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SEPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sepq_pkg.sv -----
// Shared definitions for the stable event priority queue.
// Holds default sizes, operation and status codes, and controller/datapath structs.
`timescale 1ns / 1ps
`default_nettype none

package sepq_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int DEF_QUEUE_DEPTH  = 64;
    localparam int DEF_NODE_ID_BITS = 14;
    localparam int DEF_TIME_BITS    = 16;

    // Operation selected by the request's mode bit.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;     // latch the incoming request, hole at the tail
        logic       rd_prev;  // read the entry just before the hole
        logic       shift;    // move the read entry into the hole, hole moves down
        logic       place;    // write the new entry into the hole, count up
        logic       rd_head;  // read the head entry
        logic       pop;      // capture the head entry, head forward, count down
        logic       emit;     // load the output register
        logic [1:0] status;   // status code for the emitted result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;     // no entries held
        logic full;      // all entries in use
        logic hole_one;  // the hole sits at logical position one
        logic later;     // the read entry has a later time than the new one
        logic out_free;  // the output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/core/sepq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sepq_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sepq_ctrl.sv -----
// Controller state machine for the event queue: sequences inserts and removes.
// Depends on sepq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "stable_event_priority_queue_assert.svh"

module sepq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_mode,
    output logic                  o_in_ready,
    input  wire sepq_pkg::t_dp_sts i_sts,
    output sepq_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_INS_RD  = 7'b0000010,
        S_INS_CMP = 7'b0000100,
        S_INS_PUT = 7'b0001000,
        S_REM_RD  = 7'b0010000,
        S_REM_POP = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       accept;
    logic       rem_empty;
    logic       flag_empty;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    // A remove taken while the queue is empty, and the flagged result it must lead to.
    assign rem_empty  = accept && (i_mode == sepq_pkg::MODE_REMOVE) && i_sts.empty;
    assign flag_empty = (r_state == S_DONE) && (r_status == sepq_pkg::STATUS_EMPTY);

    // Next state and command decode.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_status   = sepq_pkg::STATUS_OK;
                    if (i_mode == sepq_pkg::MODE_INSERT) begin
                        if (i_sts.full) begin
                            n_status = sepq_pkg::STATUS_FULL;
                            n_state  = S_DONE;
                        end else if (i_sts.empty) begin
                            n_state = S_INS_PUT;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end else begin
                        if (i_sts.empty) begin
                            n_status = sepq_pkg::STATUS_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_REM_RD;
                        end
                    end
                end
            end
            S_INS_RD: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (i_sts.later) begin
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.hole_one ? S_INS_PUT : S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                o_cmd.place = 1'b1;
                n_state     = S_DONE;
            end
            S_REM_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_REM_POP;
            end
            S_REM_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= sepq_pkg::STATUS_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    `SEPQ_ASSERT_ALWAYS(a_state_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `SEPQ_ASSERT_NXT(a_emit_to_idle, i_clk, i_rst_n, o_cmd.emit, r_state == S_IDLE, "no return to idle after emit")
    `SEPQ_ASSERT_NXT(a_empty_flag, i_clk, i_rst_n, rem_empty, flag_empty, "empty remove not flagged")

endmodule

`default_nettype wire

// ----- rtl/core/sepq_datapath.sv -----
// Datapath for the event queue: circular sorted store in RAM, pointers and output register.
// Depends on sepq_pkg, sepq_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "stable_event_priority_queue_assert.svh"

module sepq_datapath #(
    parameter int QUEUE_DEPTH  = sepq_pkg::DEF_QUEUE_DEPTH,
    parameter int NODE_ID_BITS = sepq_pkg::DEF_NODE_ID_BITS,
    parameter int TIME_BITS    = sepq_pkg::DEF_TIME_BITS,
    parameter int OUT_W        = 40
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [NODE_ID_BITS-1:0] i_node,
    input  wire logic [TIME_BITS-1:0]    i_time,
    input  wire logic                    i_action,
    input  wire sepq_pkg::t_dp_cmd       i_cmd,
    output sepq_pkg::t_dp_sts            o_sts,
    output logic                         o_m_valid,
    input  wire logic                    i_m_ready,
    output logic [OUT_W-1:0]             o_m_data,
    output logic [1:0]                   o_m_status
);

    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = NODE_ID_BITS + TIME_BITS + 1;
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

    // Entry layout from the lowest bit: node, time, action.
    logic [ENTRY_W-1:0]      r_new;
    logic [AW-1:0]           r_head;
    logic [AW-1:0]           r_hole;
    logic [CW-1:0]           r_count;
    logic [NODE_ID_BITS-1:0] r_res_node;
    logic [TIME_BITS-1:0]    r_res_time;
    logic                    r_res_action;
    logic                    r_m_valid;
    logic [OUT_W-1:0]        r_m_data;
    logic [1:0]              r_m_status;

    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    logic [TIME_BITS-1:0] rd_time, new_time;

    // Logical position to RAM address, wrapping once past the end.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] k);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, k};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign rd_time  = rd_data[NODE_ID_BITS +: TIME_BITS];
    assign new_time = r_new[NODE_ID_BITS +: TIME_BITS];

    // RAM port control.
    assign wr_en   = i_cmd.shift | i_cmd.place;
    assign wr_addr = phys(r_head, r_hole);
    assign wr_data = i_cmd.shift ? rd_data : r_new;
    assign rd_en   = i_cmd.rd_prev | i_cmd.rd_head;
    assign rd_addr = i_cmd.rd_head ? r_head : phys(r_head, r_hole - AW'(1));

    sepq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Status towards the controller.
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == DEPTH_C);
    assign o_sts.hole_one = (r_hole == AW'(1));
    assign o_sts.later    = (rd_time > new_time);
    assign o_sts.out_free = !r_m_valid || i_m_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                r_head  <= (r_head == LAST_A) ? '0 : r_head + AW'(1);
            end
        end
    end

    // Request latch, insertion hole and removed entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new        <= {i_action, i_time, i_node};
            r_hole       <= r_count[AW-1:0];
            r_res_node   <= '0;
            r_res_time   <= '0;
            r_res_action <= 1'b0;
        end else begin
            if (i_cmd.shift) begin
                r_hole <= r_hole - AW'(1);
            end
            if (i_cmd.pop) begin
                r_res_node   <= rd_data[NODE_ID_BITS-1:0];
                r_res_time   <= rd_time;
                r_res_action <= rd_data[ENTRY_W-1];
            end
        end
    end

    // Output register: holds a result until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_m_data   <= OUT_W'({r_count, r_res_action, r_res_time, r_res_node});
            r_m_status <= i_cmd.status;
        end
    end

    assign o_m_valid  = r_m_valid;
    assign o_m_data   = r_m_data;
    assign o_m_status = r_m_status;

    `SEPQ_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= DEPTH_C, "fill count beyond depth")
    `SEPQ_ASSERT_NXT(a_place_count, i_clk, i_rst_n, i_cmd.place, r_count == $past(r_count) + CW'(1), "insert did not raise count")
    `SEPQ_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop || i_cmd.rd_head, r_count != '0, "head read on empty store")

endmodule

`default_nettype wire

// ----- rtl/core/stable_event_priority_queue.sv -----
// Channel      | Dir | Fields (lowest bit first)
// s_axis       | in  | tdata: node_id, event_time, action_kind; tuser: mode
// m_axis       | out | tdata: out_node, out_time, out_action, occupancy; tuser: status
//
// One request at a time. Once accepted, a remove reads and pops the head entry; an insert
// reads and shifts up each held entry with a later time (a read and a write on the entry
// RAM each), skips the final read and compare at the front, then writes the new entry. A
// remove on an empty queue or an insert on a full one does neither. Each then loads the
// output register; s_axis_tready rises again on the edge that raises m_axis_tvalid. A result
// waits there while the next request is taken; only a second one stalls behind an untaken one.
// Reset is synchronous, active low; it empties the queue, no clearing pass is run.
// Top level of the stable event priority queue; depends on sepq_pkg, sepq_ctrl, sepq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module stable_event_priority_queue #(
    parameter int QUEUE_DEPTH  = sepq_pkg::DEF_QUEUE_DEPTH,
    parameter int NODE_ID_BITS = sepq_pkg::DEF_NODE_ID_BITS,
    parameter int TIME_BITS    = sepq_pkg::DEF_TIME_BITS,
    parameter int IN_W  = ((NODE_ID_BITS + TIME_BITS + 1 + 7) / 8) * 8,
    parameter int OUT_W = ((NODE_ID_BITS + TIME_BITS + 1 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // node_id, event_time, action_kind
    input  wire logic             s_axis_tuser,   // mode
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // out_node, out_time, out_action, occupancy
    output logic [1:0]            m_axis_tuser    // status
);

    sepq_pkg::t_dp_cmd cmd;
    sepq_pkg::t_dp_sts sts;

    sepq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sepq_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .NODE_ID_BITS (NODE_ID_BITS),
        .TIME_BITS    (TIME_BITS),
        .OUT_W        (OUT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_node     (s_axis_tdata[NODE_ID_BITS-1:0]),
        .i_time     (s_axis_tdata[NODE_ID_BITS +: TIME_BITS]),
        .i_action   (s_axis_tdata[NODE_ID_BITS + TIME_BITS]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_data   (m_axis_tdata),
        .o_m_status (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for stable_event_priority_queue.
// Drives insert and remove requests over the slave stream, predicts each result
// from its own sorted event list, and checks every field; depends on sepq_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int NODE_W  = sepq_pkg::DEF_NODE_ID_BITS;
    localparam int TIME_W  = sepq_pkg::DEF_TIME_BITS;
    localparam int DEPTH   = sepq_pkg::DEF_QUEUE_DEPTH;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int IN_W    = ((NODE_W + TIME_W + 1 + 7) / 8) * 8;
    localparam int OUT_W   = ((NODE_W + TIME_W + 1 + OCC_W + 7) / 8) * 8;
    localparam int TIME_LO = NODE_W;
    localparam int ACT_BIT = NODE_W + TIME_W;
    localparam int OCC_LO  = ACT_BIT + 1;
    localparam int CLK_HALF = 6;
    localparam int DIR_ROWS = 24;
    localparam int SETTLE_CYCLES = 160;

    // One queued event and one result as they appear on the streams.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] ev_time;
        logic              action;
    } ev_slot_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] ev_time;
        logic              action;
        logic [1:0]        status;
        logic [OCC_W-1:0]  occupancy;
    } ev_result_t;

    // A directed row; where known is set, the result is typed in by hand.
    typedef struct packed {
        logic       mode;
        ev_slot_t   ev;
        logic       known;
        ev_result_t res;
    } dir_row_t;

    localparam ev_result_t NO_RESULT = '0;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;   // node_id, event_time, action_kind
    logic              s_axis_tuser = 1'b0; // mode
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // out_node, out_time, out_action, occupancy
    logic [1:0]        m_axis_tuser;        // status

    // Predicted queue contents, kept sorted by time with ties in arrival order.
    ev_slot_t   held_events[$];
    ev_result_t pending_results[$];

    int  fail_count = 0;
    int  accepted_count = 0;
    int  checked_count = 0;
    int  full_drops = 0;
    int  empty_removes = 0;
    int  peak_occupancy = 0;
    bit  burst_phase = 1'b0;

    // Removes on empty, extremes, ties at equal times and a new head and tail.
    dir_row_t directed_rows [0:DIR_ROWS-1] = '{
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b1,
          '{14'h0000, 16'h0000, 1'b0, sepq_pkg::STATUS_EMPTY, 7'd0}},
        '{sepq_pkg::MODE_REMOVE, '{14'h3FFF, 16'hFFFF, 1'b1}, 1'b1,
          '{14'h0000, 16'h0000, 1'b0, sepq_pkg::STATUS_EMPTY, 7'd0}},
        '{sepq_pkg::MODE_INSERT, '{14'h3FFF, 16'hFFFF, 1'b1}, 1'b1,
          '{14'h0000, 16'h0000, 1'b0, sepq_pkg::STATUS_OK, 7'd1}},
        '{sepq_pkg::MODE_INSERT, '{14'h0000, 16'h0000, 1'b0}, 1'b1,
          '{14'h0000, 16'h0000, 1'b0, sepq_pkg::STATUS_OK, 7'd2}},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b1,
          '{14'h0000, 16'h0000, 1'b0, sepq_pkg::STATUS_OK, 7'd1}},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b1,
          '{14'h3FFF, 16'hFFFF, 1'b1, sepq_pkg::STATUS_OK, 7'd0}},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b1,
          '{14'h0000, 16'h0000, 1'b0, sepq_pkg::STATUS_EMPTY, 7'd0}},
        '{sepq_pkg::MODE_INSERT, '{14'h2AAA, 16'h5555, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_INSERT, '{14'h1555, 16'h5555, 1'b1}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_INSERT, '{14'h0003, 16'h00AA, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_INSERT, '{14'h0004, 16'h5555, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_INSERT, '{14'h0005, 16'hAAAA, 1'b1}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_INSERT, '{14'h0006, 16'h00AA, 1'b1}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_INSERT, '{14'h0007, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_INSERT, '{14'h0008, 16'hFFFF, 1'b1}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_REMOVE, '{14'h3FFF, 16'hFFFF, 1'b1}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
        '{sepq_pkg::MODE_REMOVE, '{14'h0000, 16'h0000, 1'b0}, 1'b1,
          '{14'h0000, 16'h0000, 1'b0, sepq_pkg::STATUS_EMPTY, 7'd0}}
    };

    stable_event_priority_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // Applies one request to the predicted queue and returns its result.
    function automatic ev_result_t queue_apply(input logic mode, input ev_slot_t ev);
        ev_result_t res;
        int         pos;
        res = '0;
        if (mode == sepq_pkg::MODE_INSERT) begin
            if (held_events.size() >= DEPTH) begin
                res.status = sepq_pkg::STATUS_FULL;
                full_drops++;
            end else begin
                // The new event goes after every held event with an equal or earlier time.
                pos = held_events.size();
                for (int k = 0; k < held_events.size(); k++) begin
                    if (held_events[k].ev_time > ev.ev_time) begin
                        pos = k;
                        break;
                    end
                end
                held_events.insert(pos, ev);
                res.status = sepq_pkg::STATUS_OK;
            end
        end else begin
            if (held_events.size() == 0) begin
                res.status = sepq_pkg::STATUS_EMPTY;
                empty_removes++;
            end else begin
                res.node    = held_events[0].node;
                res.ev_time = held_events[0].ev_time;
                res.action  = held_events[0].action;
                res.status  = sepq_pkg::STATUS_OK;
                void'(held_events.pop_front());
            end
        end
        res.occupancy = OCC_W'(held_events.size());
        if (held_events.size() > peak_occupancy) begin
            peak_occupancy = held_events.size();
        end
        return res;
    endfunction

    // Idle cycles before the next request: mostly none or a few, now and then many.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_phase || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Sends one request, records its expected result once it is accepted.
    task automatic send_request(input logic mode, input ev_slot_t ev,
                                input logic known, input ev_result_t typed_res);
        ev_result_t res;
        int         gap;
        gap = pick_gap();
        for (int g = 0; g < gap; g++) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= IN_W'({ev.action, ev.ev_time, ev.node});
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        accepted_count++;
        res = queue_apply(mode, ev);
        pending_results.push_back(known ? typed_res : res);
    endtask

    // Random event with times drawn so that ties and the extremes come up often.
    function automatic ev_slot_t random_event();
        ev_slot_t ev;
        int       r;
        ev.node   = NODE_W'($urandom);
        ev.action = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 40) begin
            ev.ev_time = TIME_W'($urandom_range(0, 7));
        end else if (r < 50) begin
            ev.ev_time = '0;
        end else if (r < 60) begin
            ev.ev_time = '1;
        end else begin
            ev.ev_time = TIME_W'($urandom);
        end
        return ev;
    endfunction

    // A run of random requests, inserting with the given percentage.
    task automatic random_segment(input int count, input int insert_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < insert_pct) begin
                send_request(sepq_pkg::MODE_INSERT, random_event(), 1'b0, NO_RESULT);
            end else begin
                send_request(sepq_pkg::MODE_REMOVE, random_event(), 1'b0, NO_RESULT);
            end
        end
    endtask

    // Result side: stalls of random length, with stretches that never stall.
    initial begin
        int  run_len;
        bit  no_stall;
        forever begin
            run_len  = $urandom_range(1, 60);
            no_stall = ($urandom_range(0, 3) == 0);
            repeat (run_len) begin
                @(negedge i_clk);
                m_axis_tready <= no_stall ? 1'b1 : ($urandom_range(0, 99) < 70);
            end
            if (!no_stall && $urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(10, 40)) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        ev_result_t want;
        ev_result_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.node      = m_axis_tdata[NODE_W-1:0];
            got.ev_time   = m_axis_tdata[TIME_LO +: TIME_W];
            got.action    = m_axis_tdata[ACT_BIT];
            got.occupancy = m_axis_tdata[OCC_LO +: OCC_W];
            got.status    = m_axis_tuser;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d occupancy %0d",
                       got.status, got.occupancy);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (got.node !== want.node) begin
                    $error("out_node: expected %0h, got %0h", want.node, got.node);
                    fail_count++;
                end
                if (got.ev_time !== want.ev_time) begin
                    $error("out_time: expected %0h, got %0h", want.ev_time, got.ev_time);
                    fail_count++;
                end
                if (got.action !== want.action) begin
                    $error("out_action: expected %0d, got %0d", want.action, got.action);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           got.occupancy);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, then drain and report.
    initial begin
        int extra;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_request(directed_rows[r].mode, directed_rows[r].ev,
                         directed_rows[r].known, directed_rows[r].res);
        end

        // Mixed traffic at several insert rates, some of it without idling.
        for (int s = 0; s < 4; s++) begin
            burst_phase = (s == 2);
            random_segment(50, (s == 0) ? 30 : (s == 1) ? 70 : (s == 2) ? 55 : 85);
        end
        burst_phase = 1'b0;

        // Fill to the brim, then push inserts against the full queue.
        while (held_events.size() < DEPTH) begin
            send_request(sepq_pkg::MODE_INSERT, random_event(), 1'b0, NO_RESULT);
        end
        extra = $urandom_range(3, 6);
        repeat (extra) send_request(sepq_pkg::MODE_INSERT, random_event(), 1'b0, NO_RESULT);
        random_segment(40, 60);

        // Drain completely, then remove from the empty queue a few times.
        while (held_events.size() > 0) begin
            send_request(sepq_pkg::MODE_REMOVE, random_event(), 1'b0, NO_RESULT);
        end
        repeat (3) send_request(sepq_pkg::MODE_REMOVE, random_event(), 1'b0, NO_RESULT);
        burst_phase = 1'b1;
        random_segment(40, 60);
        burst_phase = 1'b0;

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d checked results, peak occupancy %0d.",
                 accepted_count, checked_count, peak_occupancy);
        $display("Inserts dropped on a full queue: %0d; removes on an empty queue: %0d.",
                 full_drops, empty_removes);
        if (fail_count == 0) begin
            $display("stable_event_priority_queue verification clean");
        end else begin
            $display("stable_event_priority_queue verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("stable_event_priority_queue verification failed");
        $finish;
    end

endmodule
